// File: rtl/biq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biq_pkg
// Shared word types, register indexes and queue depths of the biquad unit.
// ----------------------------------------------------------------------------
package biq_pkg;

    localparam int DATA_W     = 32;
    localparam int ACC_W      = 64;
    localparam int SHIFT_W    = 5;
    localparam int CHAN_IDX_W = 3;  // holds any channel index up to eight channels
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DEPTH   = 2;
    localparam int OUT_DEPTH  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_SHIFT = 3'd5;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_in;
        logic [1:0]               channel_sel;
        logic                     mix_enable;
        logic signed [DATA_W-1:0] mix_value;
        logic                     block_end;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_out;
        logic                     block_end_out;
    } t_out_word;

    // classified sample as handed from the front to the back
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] mixv;
        logic [CHAN_IDX_W-1:0]    chan;
        logic                     chan_ok;
        logic                     mix_en;
        logic                     bend;
    } t_task;

endpackage

// File: rtl/biquad_iir_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_iir_filter_unit
// Fixed-point direct form I biquad with per-channel history.
// ----------------------------------------------------------------------------
// Samples enter through a two-word input queue and leave through a four-word
// result queue, passing through the input queue, the multiply stage and the
// sum stage. Samples of different channels issue one per cycle while result
// credit is free; a sample waits while one of its channel is in the multiply
// or sum stage, since its multiply needs that output written back from the
// sum stage. Samples with an out-of-range channel use a zero history and
// never wait for a write-back. Write coefficients and the shift through the
// plain write port only while the unit is idle; the unit does not enforce it.
module biquad_iir_filter_unit #(
    parameter int CHANNEL_COUNT = 3,
    parameter int SAMPLE_WIDTH  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    input  biq_pkg::t_in_word             i_data,
    output logic                          full,
    output logic                          empty,
    input  logic                          pop,
    output biq_pkg::t_out_word            o_data,
    input  logic                          i_cfg_we,
    input  logic [biq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [biq_pkg::DATA_W-1:0]    i_cfg_wdata
);
    import biq_pkg::*;

    t_task task_q;
    logic  task_vld;
    logic  take;

    biq_front #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .SAMPLE_WIDTH  (SAMPLE_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (i_data),
        .o_full     (full),
        .i_take     (take),
        .o_task     (task_q),
        .o_task_vld (task_vld)
    );

    biq_back #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_task      (task_q),
        .i_task_vld  (task_vld),
        .o_take      (take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_data      (o_data)
    );

endmodule

// File: rtl/biq_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biq_queue
// Small register queue with show-ahead read, generic width and depth.
// ----------------------------------------------------------------------------
module biq_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/biq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biq_front
// Accepts input words, sign-extends samples, checks the channel and queues
// the classified sample for the back.
// ----------------------------------------------------------------------------
module biq_front #(
    parameter int CHANNEL_COUNT = 3,
    parameter int SAMPLE_WIDTH  = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  biq_pkg::t_in_word i_data,
    output logic              o_full,
    input  logic              i_take,
    output biq_pkg::t_task    o_task,
    output logic              o_task_vld
);
    import biq_pkg::*;

    t_task cls;
    logic  q_empty;

    always_comb begin
        cls.x       = DATA_W'($signed(i_data.sample_in[SAMPLE_WIDTH-1:0]));
        cls.mixv    = DATA_W'($signed(i_data.mix_value[SAMPLE_WIDTH-1:0]));
        cls.chan    = CHAN_IDX_W'(i_data.channel_sel);
        cls.chan_ok = (32'(i_data.channel_sel) < CHANNEL_COUNT);
        cls.mix_en  = i_data.mix_enable;
        cls.bend    = i_data.block_end;
    end

    biq_queue #(
        .WIDTH ($bits(t_task)),
        .DEPTH (IN_DEPTH)
    ) u_in_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_data  (o_task),
        .o_empty (q_empty)
    );

    assign o_task_vld = !q_empty;

endmodule

// File: rtl/biq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biq_back
// Coefficient registers, channel history, multiply and sum stages, and the
// result queue.
// ----------------------------------------------------------------------------
module biq_back #(
    parameter int CHANNEL_COUNT = 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [biq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [biq_pkg::DATA_W-1:0]       i_cfg_wdata,
    input  biq_pkg::t_task                   i_task,
    input  logic                             i_task_vld,
    output logic                             o_take,
    output logic                             o_empty,
    input  logic                             i_pop,
    output biq_pkg::t_out_word               o_data
);
    import biq_pkg::*;

    localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int CRED_W = $clog2(OUT_DEPTH + 1);

    logic signed [DATA_W-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;
    logic [SHIFT_W-1:0]       r_shift;

    logic signed [DATA_W-1:0] r_id1 [CHANNEL_COUNT];
    logic signed [DATA_W-1:0] r_id2 [CHANNEL_COUNT];
    logic signed [DATA_W-1:0] r_od1 [CHANNEL_COUNT];
    logic signed [DATA_W-1:0] r_od2 [CHANNEL_COUNT];

    // multiply stage
    logic                     r_s1_vld;
    t_task                    r_s1;
    logic signed [DATA_W-1:0] r_s1_x1, r_s1_y1;
    logic signed [ACC_W-1:0]  r_p0, r_p1, r_p2, r_p3, r_p4;

    // sum stage
    logic                     r_s2_vld;
    t_task                    r_s2;
    logic signed [DATA_W-1:0] r_s2_x1, r_s2_y1;
    logic [ACC_W-1:0]         r_acc;

    logic [CRED_W-1:0]        r_credit, n_credit;

    logic [CH_W-1:0]          rd_idx, wr_idx;
    logic signed [DATA_W-1:0] x1, x2, y1, y2;
    logic                     hazard, issue, out_pop;
    logic [ACC_W-1:0]         shifted;
    logic [DATA_W-1:0]        y;
    t_out_word                res;

    assign rd_idx = CH_W'(i_task.chan);
    assign wr_idx = CH_W'(r_s2.chan);

    always_comb begin
        x1 = '0;
        x2 = '0;
        y1 = '0;
        y2 = '0;
        if (i_task.chan_ok) begin
            x1 = r_id1[rd_idx];
            x2 = r_id2[rd_idx];
            y1 = r_od1[rd_idx];
            y2 = r_od2[rd_idx];
        end
    end

    // hold a sample while an earlier one of its channel has not yet written back
    assign hazard = i_task.chan_ok &&
                    ((r_s1_vld && r_s1.chan_ok && r_s1.chan == i_task.chan) ||
                     (r_s2_vld && r_s2.chan_ok && r_s2.chan == i_task.chan));
    assign issue  = i_task_vld && !hazard && (r_credit < CRED_W'(OUT_DEPTH));
    assign o_take = issue;

    assign shifted = r_acc << r_shift;
    assign y       = shifted[ACC_W-1:ACC_W-DATA_W];

    always_comb begin
        res.sample_out    = r_s2.mix_en ? r_s2.mixv + y : y;
        res.block_end_out = r_s2.bend;
    end

    assign out_pop  = i_pop && !o_empty;
    assign n_credit = r_credit + CRED_W'(issue) - CRED_W'(out_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0    <= '1;
            r_b1    <= '0;
            r_b2    <= '0;
            r_a1    <= '0;
            r_a2    <= '0;
            r_shift <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COEF_B0:    r_b0    <= i_cfg_wdata;
                CFG_COEF_B1:    r_b1    <= i_cfg_wdata;
                CFG_COEF_B2:    r_b2    <= i_cfg_wdata;
                CFG_COEF_A1:    r_a1    <= i_cfg_wdata;
                CFG_COEF_A2:    r_a2    <= i_cfg_wdata;
                CFG_POST_SHIFT: r_shift <= i_cfg_wdata[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                r_id1[i] <= '0;
                r_id2[i] <= '0;
                r_od1[i] <= '0;
                r_od2[i] <= '0;
            end
        end else if (r_s2_vld && r_s2.chan_ok) begin
            r_id2[wr_idx] <= r_s2_x1;
            r_id1[wr_idx] <= r_s2.x;
            r_od2[wr_idx] <= r_s2_y1;
            r_od1[wr_idx] <= y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_credit <= '0;
        end else begin
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
            r_credit <= n_credit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1    <= i_task;
        r_s1_x1 <= x1;
        r_s1_y1 <= y1;
        r_p0    <= i_task.x * r_b0;
        r_p1    <= x1 * r_b1;
        r_p2    <= x2 * r_b2;
        r_p3    <= y1 * r_a1;
        r_p4    <= y2 * r_a2;

        r_s2    <= r_s1;
        r_s2_x1 <= r_s1_x1;
        r_s2_y1 <= r_s1_y1;
        r_acc   <= ACC_W'(r_p0 + r_p1 + r_p2 + r_p3 + r_p4);
    end

    // credits keep this queue from ever overflowing
    biq_queue #(
        .WIDTH ($bits(t_out_word)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_vld),
        .i_data  (res),
        .o_full  (),
        .i_pop   (i_pop),
        .o_data  (o_data),
        .o_empty (o_empty)
    );

endmodule

// File: rtl/biq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biq_checker
// Port-level checks of word accounting and latency for the biquad unit.
// ----------------------------------------------------------------------------
module biq_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic push,
    input logic full,
    input logic empty,
    input logic pop
);
    import biq_pkg::*;

    logic [3:0] r_cnt;
    logic       acc_in, acc_out;

    assign acc_in  = push && !full;
    assign acc_out = pop && !empty;

    // count words accepted but not yet popped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 4'(acc_in) - 4'(acc_out);
        end
    end

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> empty)
        else $error("result shown with no word outstanding");

    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_cnt == '0) && acc_in) |=> empty)
        else $error("result appeared one cycle after accept");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (r_cnt >= 4'(IN_DEPTH)))
        else $error("full raised with input queue not filled");

endmodule

bind biquad_iir_filter_unit biq_checker u_biq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop)
);

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for biquad_iir_filter_unit. A behavioral copy of the
// filter tracks per-channel history and coefficients, predicts every result
// word and compares it field by field with what the unit pops. Covers reset
// coefficients, extreme and random settings, out-of-range channels, sum and
// mix wrap, random idles on both queues and a full-queue backpressure stretch.
// ----------------------------------------------------------------------------
module tb;
    import biq_pkg::*;

    localparam int          CHANNELS        = 3;
    localparam int          PHASES          = 6;
    localparam int          PHASE_WORDS     = 255;
    localparam int          RX_HOLD_CYCLES  = 150;
    localparam int          SETTLE_CYCLES   = 6;
    localparam int unsigned CYCLE_LIMIT     = 400000;

    localparam logic [1:0] CHAN_MONO  = 2'd0;
    localparam logic [1:0] CHAN_LEFT  = 2'd1;
    localparam logic [1:0] CHAN_RIGHT = 2'd2;
    localparam logic [1:0] CHAN_NONE  = 2'd3;  // beyond CHANNELS

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [DATA_W-1:0] S_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] S_MAX = 32'h7fff_ffff;

    // Filter behavior plus the queue of result words still owed by the unit.
    class biquad_response;
        logic [DATA_W-1:0]  b0, b1, b2, a1, a2;
        logic [SHIFT_W-1:0] shift;
        logic [DATA_W-1:0]  x_d1 [CHANNELS];
        logic [DATA_W-1:0]  x_d2 [CHANNELS];
        logic [DATA_W-1:0]  y_d1 [CHANNELS];
        logic [DATA_W-1:0]  y_d2 [CHANNELS];
        t_out_word          owed_q [$];
        int unsigned        mismatches;

        function new();
            b0 = '1;
            b1 = '0;
            b2 = '0;
            a1 = '0;
            a2 = '0;
            shift = '0;
            mismatches = 0;
            for (int c = 0; c < CHANNELS; c++) begin
                x_d1[c] = '0;
                x_d2[c] = '0;
                y_d1[c] = '0;
                y_d2[c] = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] v);
            case (idx)
                CFG_COEF_B0:    b0 = v;
                CFG_COEF_B1:    b1 = v;
                CFG_COEF_B2:    b2 = v;
                CFG_COEF_A1:    a1 = v;
                CFG_COEF_A2:    a2 = v;
                CFG_POST_SHIFT: shift = v[SHIFT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [ACC_W-1:0] product(logic [DATA_W-1:0] p, logic [DATA_W-1:0] q);
            longint sp, sq;
            sp = $signed(p);
            sq = $signed(q);
            return sp * sq;
        endfunction

        function void note_sample(t_in_word w);
            logic [DATA_W-1:0] x1, x2, y1, y2, y;
            logic [ACC_W-1:0]  acc;
            bit                in_range;
            t_out_word         res;
            in_range = (int'(w.channel_sel) < CHANNELS);
            x1 = '0;
            x2 = '0;
            y1 = '0;
            y2 = '0;
            if (in_range) begin
                x1 = x_d1[w.channel_sel];
                x2 = x_d2[w.channel_sel];
                y1 = y_d1[w.channel_sel];
                y2 = y_d2[w.channel_sel];
            end
            acc = product(w.sample_in, b0) + product(x1, b1) + product(x2, b2)
                + product(y1, a1) + product(y2, a2);
            acc = acc << shift;
            y = acc[ACC_W-1:DATA_W];
            // out-of-range channel filters with zero history and leaves state alone
            if (in_range) begin
                x_d2[w.channel_sel] = x1;
                x_d1[w.channel_sel] = w.sample_in;
                y_d2[w.channel_sel] = y1;
                y_d1[w.channel_sel] = y;
            end
            res.sample_out    = w.mix_enable ? w.mix_value + y : y;
            res.block_end_out = w.block_end;
            owed_q.push_back(res);
        endfunction

        task report(string what);
            mismatches++;
            $display("tb: mismatch at %0t: %s", $realtime, what);
        endtask

        task check_result(t_out_word got);
            t_out_word want;
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected word sample_out=%h", got.sample_out));
                return;
            end
            want = owed_q.pop_front();
            if (got.sample_out !== want.sample_out)
                report($sformatf("sample_out %h, wanted %h", got.sample_out, want.sample_out));
            if (got.block_end_out !== want.block_end_out)
                report($sformatf("block_end_out %b, wanted %b",
                                 got.block_end_out, want.block_end_out));
        endtask

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    t_in_word              i_data;
    logic                  full;
    logic                  empty;
    logic                  pop;
    t_out_word             o_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [DATA_W-1:0]     i_cfg_wdata;

    biquad_response response = new();
    int                    idle_pct = 12;
    bit                    steady_push = 1'b0;
    bit                    hold_req = 1'b0;
    int unsigned           cycle_count = 0;

    biquad_iir_filter_unit #(
        .CHANNEL_COUNT(CHANNELS),
        .SAMPLE_WIDTH (DATA_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_data     (i_data),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: pop with random bursts of idles, plus one long hold on request.
    initial begin : result_side
        int unsigned hold_left;
        int unsigned burst_left;
        hold_left = 0;
        burst_left = 0;
        pop <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (pop && !empty)
                response.check_result(o_data);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (burst_left != 0) begin
                burst_left--;
                pop <= 1'b0;
            end else if ($urandom_range(1, 100) <= idle_pct) begin
                burst_left = $urandom_range(0, 16);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic logic [DATA_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return S_MIN;
            1: return S_MAX;
            2: return '0;
            3: return DATA_W'($urandom_range(0, 511)) - DATA_W'(256);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        w.sample_in   = random_sample();
        w.channel_sel = ($urandom_range(0, 7) == 0) ? CHAN_NONE : 2'($urandom_range(0, 2));
        w.mix_enable  = 1'($urandom_range(0, 1));
        w.mix_value   = random_sample();
        w.block_end   = ($urandom_range(0, 7) == 0);
        return w;
    endfunction

    task automatic push_word(input t_in_word w);
        if (!steady_push && $urandom_range(1, 100) <= idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        response.note_sample(w);
    endtask

    task automatic send(input logic [DATA_W-1:0] x, input logic [1:0] ch,
                        input logic mix_en, input logic [DATA_W-1:0] mixv,
                        input logic bend);
        t_in_word w;
        w.sample_in   = x;
        w.channel_sel = ch;
        w.mix_enable  = mix_en;
        w.mix_value   = mixv;
        w.block_end   = bend;
        push_word(w);
    endtask

    // Drop push and wait until every owed word has been popped.
    task automatic settle();
        push <= 1'b0;
        while (response.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        response.write_reg(idx, v);
    endtask

    task automatic program_regs(input logic [DATA_W-1:0] c0, input logic [DATA_W-1:0] c1,
                                input logic [DATA_W-1:0] c2, input logic [DATA_W-1:0] c3,
                                input logic [DATA_W-1:0] c4, input logic [SHIFT_W-1:0] sh);
        put_reg(CFG_COEF_B0, c0);
        put_reg(CFG_COEF_B1, c1);
        put_reg(CFG_COEF_B2, c2);
        put_reg(CFG_COEF_A1, c3);
        put_reg(CFG_COEF_A2, c4);
        // upper bits of the shift word must be masked off
        put_reg(CFG_POST_SHIFT, {27'($urandom), sh});
        put_reg(CFG_SPARE_LO, $urandom);
        put_reg(CFG_SPARE_HI, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_data <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_wdata <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset coefficients: y is the top word of -x
        send(S_MAX, CHAN_MONO, 1'b0, '0, 1'b1);
        send(S_MIN, CHAN_LEFT, 1'b1, S_MAX, 1'b0);
        send('0, CHAN_RIGHT, 1'b1, S_MIN, 1'b1);
        send('1, CHAN_NONE, 1'b0, '1, 1'b0);
        send(32'd1, CHAN_MONO, 1'b1, S_MAX, 1'b0);
        send(S_MIN, CHAN_MONO, 1'b1, S_MIN, 1'b1);
        send(S_MAX, CHAN_NONE, 1'b1, S_MAX, 1'b1);
        send('1, CHAN_RIGHT, 1'b0, '0, 1'b0);
        settle();

        // mixed extremes with the top shift: sum and mix wrap
        program_regs(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, 5'd31);
        for (int i = 0; i < 4; i++)
            send(S_MIN, CHAN_MONO, 1'b1, S_MAX, i[0]);
        send(S_MAX, CHAN_MONO, 1'b1, S_MIN, 1'b0);
        send(S_MAX, CHAN_NONE, 1'b1, S_MAX, 1'b1);
        send(S_MIN, CHAN_LEFT, 1'b0, '0, 1'b0);
        send(S_MIN, CHAN_LEFT, 1'b1, S_MAX, 1'b1);
        send('1, CHAN_RIGHT, 1'b1, '1, 1'b0);
        send(S_MAX, CHAN_RIGHT, 1'b1, S_MAX, 1'b1);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: program_regs(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 5'd0);
                1: program_regs(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 5'd31);
                default: program_regs(random_sample(), random_sample(), random_sample(),
                                      random_sample(), random_sample(),
                                      5'($urandom_range(0, 31)));
            endcase
            idle_pct = (p == PHASES - 1) ? 0 : (p == 1) ? 3 : 12;
            for (int i = 0; i < PHASE_WORDS; i++) begin
                // hold the result side and keep pushing so both queues fill
                if (p == 2 && i == 0) begin
                    hold_req = 1'b1;
                    steady_push = 1'b1;
                end
                if (p == 2 && i == 40)
                    steady_push = 1'b0;
                if (p == 3 && i == PHASE_WORDS / 2) begin
                    push <= 1'b0;
                    while (response.pending() != 0) @(posedge i_clk);
                end
                push_word(random_word());
            end
            settle();
        end

        if (response.pending() != 0)
            response.report($sformatf("%0d result words never arrived", response.pending()));
        if (response.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/biq_pkg.sv
rtl/biq_queue.sv
rtl/biq_front.sv
rtl/biq_back.sv
rtl/biquad_iir_filter_unit.sv
rtl/biq_checker.sv
test/tb.sv
